// ----- sv/h264au_pkg.sv -----
package h264au_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int OUT_W = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
    localparam logic [4:0] NAL_AUD = 5'd9;
    localparam logic [4:0] NAL_IDR = 5'd5;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE = 8'h01;
    localparam logic [1:0] ZRUN_MAX = 2'd3;
    localparam logic [1:0] ZRUN_MIN_SC = 2'd2;

    typedef logic [OFFSET_BITS-1:0] t_ofs;

    // Descriptors produced by one input byte: an optional unit closed by a
    // delimiter and an optional final unit (or error) at the stream end.
    typedef struct packed {
        logic has_close;
        t_ofs close_ofs;
        t_ofs close_len;
        logic close_key;
        logic has_final;
        t_ofs fin_ofs;
        t_ofs fin_len;
        logic fin_key;
        logic fin_nodelim;
    } t_job;

    function automatic logic [OUT_W-1:0] ofs_to_out(input t_ofs v);
        logic [OFFSET_BITS+OUT_W-1:0] ext;
        ext = {{OUT_W{1'b0}}, v};
        return ext[OUT_W-1:0];
    endfunction

endpackage

// ----- sv/h264au_in_if.sv -----
interface h264au_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       stream_end;

    modport source (output valid, output byte_value, output stream_end, input ready);
    modport sink (input valid, input byte_value, input stream_end, output ready);
endinterface

// ----- sv/h264au_out_if.sv -----
interface h264au_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] unit_offset;
    logic [31:0] unit_length;
    logic        is_keyframe;
    logic        no_delimiter;
    logic        last_of_run;

    modport source (output valid, output unit_offset, output unit_length,
                    output is_keyframe, output no_delimiter, output last_of_run,
                    input ready);
    modport sink (input valid, input unit_offset, input unit_length,
                  input is_keyframe, input no_delimiter, input last_of_run,
                  output ready);
endinterface

// ----- sv/h264_access_unit_splitter_unit.sv -----
// Splits an H.264 Annex B byte stream into access units, one byte per item at
// one item per clock cycle while the queue has room. The front end scans for
// start codes, reads each NAL header and closes a unit at every access unit
// delimiter after the first; the descriptors it makes go through a four-entry
// queue to a registered output stage, so the input keeps running while a
// descriptor waits to be taken. Each descriptor is queued, then registered
// at the output. A closing delimiter header that is also the stream's last
// byte yields two output items, sent in turn; the final byte always yields
// the last unit or a no-delimiter error; all offsets then restart at zero.
module h264_access_unit_splitter_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    h264au_in_if.sink      i_in,
    h264au_out_if.source   o_out
);

    logic             q_full;
    logic             push;
    h264au_pkg::t_job push_job;
    logic             q_valid;
    h264au_pkg::t_job head_job;
    logic             pop;

    h264au_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_byte_value (i_in.byte_value),
        .i_stream_end (i_in.stream_end),
        .i_q_full     (q_full),
        .o_ready      (i_in.ready),
        .o_push       (push),
        .o_job        (push_job)
    );

    h264au_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    h264au_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_job          (head_job),
        .o_pop          (pop),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_unit_offset  (o_out.unit_offset),
        .o_unit_length  (o_out.unit_length),
        .o_is_keyframe  (o_out.is_keyframe),
        .o_no_delimiter (o_out.no_delimiter),
        .o_last_of_run  (o_out.last_of_run)
    );

endmodule

// ----- sv/h264au_front.sv -----
module h264au_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte_value,
    input  logic               i_stream_end,
    input  logic               i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output h264au_pkg::t_job   o_job
);

    h264au_pkg::t_ofs r_byte_count, n_byte_count;
    logic [1:0]       r_zero_run, n_zero_run;
    logic             r_header_due, n_header_due;
    h264au_pkg::t_ofs r_prefix_start, n_prefix_start;
    logic             r_seen_delim, n_seen_delim;
    h264au_pkg::t_ofs r_unit_begin, n_unit_begin;
    logic             r_unit_idr, n_unit_idr;

    logic             accept;
    logic [4:0]       nal_type;
    logic             is_aud;
    logic             is_idr;
    logic             close;
    logic             seen_after;
    h264au_pkg::t_ofs begin_after;
    logic             idr_after;
    h264au_pkg::t_ofs back_ofs;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign nal_type = 5'(i_byte_value & h264au_pkg::NAL_TYPE_MASK);
    assign is_aud   = r_header_due && (nal_type == h264au_pkg::NAL_AUD);
    assign is_idr   = r_header_due && (nal_type == h264au_pkg::NAL_IDR);
    assign close    = is_aud && r_seen_delim;

    assign seen_after  = r_seen_delim || is_aud;
    assign begin_after = close ? r_prefix_start : r_unit_begin;
    assign idr_after   = close ? 1'b0 : (r_unit_idr || is_idr);
    assign back_ofs    = (r_zero_run == h264au_pkg::ZRUN_MAX) ? h264au_pkg::t_ofs'(3)
                                                               : h264au_pkg::t_ofs'(2);

    always_comb begin
        o_job.has_close   = close;
        o_job.close_ofs   = r_unit_begin;
        o_job.close_len   = r_prefix_start - r_unit_begin;
        o_job.close_key   = r_unit_idr;
        o_job.has_final   = i_stream_end;
        o_job.fin_ofs     = seen_after ? begin_after : '0;
        o_job.fin_len     = seen_after ? (r_byte_count + h264au_pkg::t_ofs'(1) - begin_after)
                                       : '0;
        o_job.fin_key     = seen_after && idr_after;
        o_job.fin_nodelim = !seen_after;
    end

    assign o_push = accept && (close || i_stream_end);

    always_comb begin
        n_byte_count   = r_byte_count;
        n_zero_run     = r_zero_run;
        n_header_due   = r_header_due;
        n_prefix_start = r_prefix_start;
        n_seen_delim   = r_seen_delim;
        n_unit_begin   = r_unit_begin;
        n_unit_idr     = r_unit_idr;
        if (accept) begin
            if (r_header_due) begin
                n_header_due = 1'b0;
                n_zero_run   = '0;
                n_seen_delim = seen_after;
                n_unit_begin = begin_after;
                n_unit_idr   = idr_after;
            end else if (i_byte_value == h264au_pkg::BYTE_ZERO) begin
                if (r_zero_run != h264au_pkg::ZRUN_MAX) begin
                    n_zero_run = r_zero_run + 2'd1;
                end
            end else if (i_byte_value == h264au_pkg::BYTE_ONE
                         && r_zero_run >= h264au_pkg::ZRUN_MIN_SC) begin
                n_prefix_start = r_byte_count - back_ofs;
                n_header_due   = 1'b1;
                n_zero_run     = '0;
            end else begin
                n_zero_run = '0;
            end
            if (i_stream_end) begin
                // The next byte starts a fresh stream at offset zero.
                n_byte_count   = '0;
                n_zero_run     = '0;
                n_header_due   = 1'b0;
                n_prefix_start = '0;
                n_seen_delim   = 1'b0;
                n_unit_begin   = '0;
                n_unit_idr     = 1'b0;
            end else begin
                n_byte_count = r_byte_count + h264au_pkg::t_ofs'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_zero_run     <= '0;
            r_header_due   <= 1'b0;
            r_prefix_start <= '0;
            r_seen_delim   <= 1'b0;
            r_unit_begin   <= '0;
            r_unit_idr     <= 1'b0;
        end else begin
            r_byte_count   <= n_byte_count;
            r_zero_run     <= n_zero_run;
            r_header_due   <= n_header_due;
            r_prefix_start <= n_prefix_start;
            r_seen_delim   <= n_seen_delim;
            r_unit_begin   <= n_unit_begin;
            r_unit_idr     <= n_unit_idr;
        end
    end

endmodule

// ----- sv/h264au_queue.sv -----
module h264au_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  h264au_pkg::t_job   i_job,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output h264au_pkg::t_job   o_job
);

    h264au_pkg::t_job                r_mem [h264au_pkg::QUEUE_DEPTH];
    logic [h264au_pkg::QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [h264au_pkg::QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [h264au_pkg::QPTR_W:0]     r_count, n_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_count == (h264au_pkg::QPTR_W+1)'(h264au_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + (h264au_pkg::QPTR_W)'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + (h264au_pkg::QPTR_W)'(1) : r_rd_ptr;
        n_count  = r_count + (h264au_pkg::QPTR_W+1)'(do_push)
                           - (h264au_pkg::QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- sv/h264au_back.sv -----
module h264au_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  h264au_pkg::t_job   i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_unit_offset,
    output logic [31:0]        o_unit_length,
    output logic               o_is_keyframe,
    output logic               o_no_delimiter,
    output logic               o_last_of_run
);

    logic        r_valid, n_valid;
    logic        r_close_done, n_close_done;
    logic [31:0] r_offset;
    logic [31:0] r_length;
    logic        r_key;
    logic        r_nodelim;
    logic        r_last;
    logic        load;
    logic        emit_close;

    assign load       = i_q_valid && (!r_valid || i_ready);
    assign emit_close = i_job.has_close && !r_close_done;
    // A job with both a closed unit and a final unit stays queued for two items.
    assign o_pop      = load && !(emit_close && i_job.has_final);

    always_comb begin
        n_valid      = r_valid;
        n_close_done = r_close_done;
        if (load) begin
            n_valid      = 1'b1;
            n_close_done = emit_close && i_job.has_final;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_close_done <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_close_done <= n_close_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (emit_close) begin
                r_offset  <= h264au_pkg::ofs_to_out(i_job.close_ofs);
                r_length  <= h264au_pkg::ofs_to_out(i_job.close_len);
                r_key     <= i_job.close_key;
                r_nodelim <= 1'b0;
                r_last    <= !i_job.has_final;
            end else begin
                r_offset  <= h264au_pkg::ofs_to_out(i_job.fin_ofs);
                r_length  <= h264au_pkg::ofs_to_out(i_job.fin_len);
                r_key     <= i_job.fin_key;
                r_nodelim <= i_job.fin_nodelim;
                r_last    <= 1'b1;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_unit_offset  = r_offset;
    assign o_unit_length  = r_length;
    assign o_is_keyframe  = r_key;
    assign o_no_delimiter = r_nodelim;
    assign o_last_of_run  = r_last;

endmodule

// ----- dv/h264_access_unit_splitter_unit_tb.sv -----
`timescale 1ns / 1ps

module h264_access_unit_splitter_unit_tb;

    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam logic [4:0] NAL_SEI = 5'd6;
    localparam logic [4:0] NAL_SPS = 5'd7;
    localparam logic [4:0] NAL_PPS = 5'd8;

    localparam int RANDOM_BYTES = 1320;
    localparam int DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] unit_offset;
        logic [31:0] unit_length;
        logic        is_keyframe;
        logic        no_delimiter;
        logic        last_of_run;
    } t_unit_desc;

    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    h264au_in_if  in_if ();
    h264au_out_if out_if ();

    h264_access_unit_splitter_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Scanner state of the splitter as the testbench sees it.
    h264au_pkg::t_ofs pos;
    logic [1:0]       zeros;
    logic             hdr_next;
    h264au_pkg::t_ofs sc_ofs;
    logic             aud_seen;
    h264au_pkg::t_ofs au_start;
    logic             au_key;

    t_unit_desc  expected_units[$];
    logic [7:0]  stream_bytes[$];
    int          err_count = 0;
    int          burst_left = 0;
    int unsigned cycle_count = 0;

    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_left = 0;
    int unsigned rx_phase = 0;

    function automatic void clear_scanner();
        pos = '0;
        zeros = '0;
        hdr_next = 1'b0;
        sc_ofs = '0;
        aud_seen = 1'b0;
        au_start = '0;
        au_key = 1'b0;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endfunction

    function automatic void add_unit(input t_unit_desc d);
        expected_units.insert(expected_units.size(), d);
    endfunction

    function automatic t_unit_desc make_unit(input h264au_pkg::t_ofs ofs,
                                             input h264au_pkg::t_ofs len,
                                             input logic key, input logic nodelim);
        t_unit_desc d;
        d.unit_offset = 32'(ofs);
        d.unit_length = 32'(len);
        d.is_keyframe = key;
        d.no_delimiter = nodelim;
        d.last_of_run = 1'b0;
        return d;
    endfunction

    // Advances the scanner by one accepted byte and queues the access units it closes.
    function automatic void predict_units(input logic [7:0] b, input logic is_last);
        t_unit_desc run[$];
        logic [4:0] nal_type;
        nal_type = 5'(b & h264au_pkg::NAL_TYPE_MASK);
        if (hdr_next) begin
            hdr_next = 1'b0;
            zeros = '0;
            if (nal_type == h264au_pkg::NAL_AUD) begin
                if (aud_seen) begin
                    run.insert(run.size(),
                               make_unit(au_start, sc_ofs - au_start, au_key, 1'b0));
                    au_start = sc_ofs;
                    au_key = 1'b0;
                end else begin
                    aud_seen = 1'b1;
                end
            end
            if (nal_type == h264au_pkg::NAL_IDR) begin
                au_key = 1'b1;
            end
        end else if (b == h264au_pkg::BYTE_ZERO) begin
            if (zeros != h264au_pkg::ZRUN_MAX) begin
                zeros = zeros + 2'd1;
            end
        end else if (b == h264au_pkg::BYTE_ONE && zeros >= h264au_pkg::ZRUN_MIN_SC) begin
            // Three or more zeros mean the four-byte start code.
            sc_ofs = pos - ((zeros == h264au_pkg::ZRUN_MAX) ? h264au_pkg::t_ofs'(3)
                                                            : h264au_pkg::t_ofs'(2));
            hdr_next = 1'b1;
            zeros = '0;
        end else begin
            zeros = '0;
        end

        if (is_last) begin
            if (aud_seen) begin
                run.insert(run.size(),
                           make_unit(au_start, pos + h264au_pkg::t_ofs'(1) - au_start,
                                     au_key, 1'b0));
            end else begin
                run.insert(run.size(), make_unit('0, '0, 1'b0, 1'b1));
            end
            clear_scanner();
        end else begin
            pos = pos + h264au_pkg::t_ofs'(1);
        end

        if (run.size() > 0) begin
            run[run.size()-1].last_of_run = 1'b1;
        end
        foreach (run[i]) begin
            add_unit(run[i]);
        end
    endfunction

    // The sender runs in bursts; a gap lowers valid only right after an accepted item.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(100, 300);
            end else begin
                burst_left = $urandom_range(1, 24);
            end
            gap = $urandom_range(1, 8);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.byte_value <= b;
        in_if.stream_end <= is_last;
        do @(posedge i_clk); while (!in_if.ready);
        predict_units(b, is_last);
    endtask

    task automatic send_stream();
        int n;
        n = stream_bytes.size();
        for (int i = 0; i < n; i++) begin
            send_byte(stream_bytes[i], i == n - 1);
        end
        stream_bytes.delete();
    endtask

    function automatic void add_start_code(input int nzeros);
        repeat (nzeros) add_byte(h264au_pkg::BYTE_ZERO);
        add_byte(h264au_pkg::BYTE_ONE);
    endfunction

    function automatic logic [7:0] nal_header(input logic [4:0] nal_type);
        return {3'($urandom_range(0, 7)), nal_type};
    endfunction

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 9))
            0, 1:    return h264au_pkg::BYTE_ZERO;
            2:       return h264au_pkg::BYTE_ONE;
            3:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int random_zero_count();
        case ($urandom_range(0, 19))
            0, 1, 2:    return $urandom_range(4, 6);
            3, 4, 5, 6, 7, 8, 9, 10: return 2;
            default:    return 3;
        endcase
    endfunction

    function automatic logic [4:0] random_nal_type();
        case ($urandom_range(0, 9))
            0, 1, 2: return h264au_pkg::NAL_IDR;
            3, 4, 5: return NAL_SLICE;
            6:       return NAL_SPS;
            7:       return NAL_PPS;
            8:       return NAL_SEI;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic void add_nal(input logic [4:0] nal_type);
        int len;
        add_start_code(random_zero_count());
        add_byte(nal_header(nal_type));
        if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(20, 48);
        end else begin
            len = $urandom_range(0, 10);
        end
        repeat (len) add_byte(payload_byte());
    endfunction

    // A stream of access units, each but possibly the first led by a delimiter, with a random ending.
    function automatic void build_au_stream();
        int n_aus;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) add_byte(payload_byte());
        end
        n_aus = $urandom_range(1, 5);
        for (int a = 0; a < n_aus; a++) begin
            // Only the first unit may lack a leading delimiter.
            if (a > 0 || $urandom_range(0, 4) != 0) begin
                add_nal(h264au_pkg::NAL_AUD);
            end
            repeat ($urandom_range(1, 3)) add_nal(random_nal_type());
        end
        case ($urandom_range(0, 9))
            0, 1: begin
                add_start_code(random_zero_count());
                add_byte(nal_header(h264au_pkg::NAL_AUD));
            end
            2: add_start_code(random_zero_count());
            3: begin
                add_start_code(random_zero_count());
                add_byte(nal_header(random_nal_type()));
            end
            default: begin
                if (stream_bytes.size() == 0) begin
                    add_byte(payload_byte());
                end
            end
        endcase
    endfunction

    function automatic void build_noise_stream();
        repeat ($urandom_range(1, 24)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: add_byte(h264au_pkg::BYTE_ZERO);
                5, 6:          add_byte(h264au_pkg::BYTE_ONE);
                default:       add_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // A one-byte stream has no delimiter and ends at once.
    task automatic test_no_delimiter();
        add_byte(8'hff);
        send_stream();
    endtask

    // Delimiters close units at their prefix, the last one being the final byte.
    task automatic test_unit_split();
        add_start_code(3);
        add_byte({3'b000, h264au_pkg::NAL_AUD});
        add_start_code(2);
        add_byte({3'b011, h264au_pkg::NAL_IDR});
        add_start_code(4);
        add_byte({3'b001, h264au_pkg::NAL_AUD});
        add_start_code(2);
        add_byte({3'b111, h264au_pkg::NAL_AUD});
        send_stream();
    endtask

    // A zero header byte does not start a zero run, and a start code on the final
    // byte has no header to read.
    task automatic test_ignored_start_codes();
        add_start_code(2);
        add_byte(h264au_pkg::BYTE_ZERO);
        add_start_code(1);
        add_start_code(2);
        send_stream();
    endtask

    task automatic test_random_streams(input int byte_goal);
        int sent;
        sent = 0;
        while (sent < byte_goal) begin
            if ($urandom_range(0, 4) == 0) begin
                build_noise_stream();
            end else begin
                build_au_stream();
            end
            sent += stream_bytes.size();
            send_stream();
        end
    endtask

    function automatic void check_unit();
        t_unit_desc got;
        t_unit_desc want;
        got.unit_offset = out_if.unit_offset;
        got.unit_length = out_if.unit_length;
        got.is_keyframe = out_if.is_keyframe;
        got.no_delimiter = out_if.no_delimiter;
        got.last_of_run = out_if.last_of_run;
        if (expected_units.size() == 0) begin
            $display("%0t: expected none, actual ofs=%h len=%h key=%b nodelim=%b last=%b",
                     $time, got.unit_offset, got.unit_length, got.is_keyframe,
                     got.no_delimiter, got.last_of_run);
            err_count++;
            return;
        end
        want = expected_units.pop_front();
        if (got !== want) begin
            $display("%0t: expected ofs=%h len=%h key=%b nodelim=%b last=%b", $time,
                     want.unit_offset, want.unit_length, want.is_keyframe,
                     want.no_delimiter, want.last_of_run);
            $display("%0t:   actual ofs=%h len=%h key=%b nodelim=%b last=%b", $time,
                     got.unit_offset, got.unit_length, got.is_keyframe,
                     got.no_delimiter, got.last_of_run);
            err_count++;
        end
    endfunction

    // Output side: check each accepted unit, then pick the next ready level.
    always @(posedge i_clk) begin
        if (out_if.valid && out_if.ready) begin
            check_unit();
        end
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 80);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:         out_if.ready <= 1'b1;
            RX_COIN:         out_if.ready <= 1'($urandom_range(0, 1));
            RX_EVERY_FOURTH: out_if.ready <= (rx_phase[1:0] == 2'd0);
            default:         out_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        in_if.valid <= 1'b0;
        in_if.byte_value <= '0;
        in_if.stream_end <= 1'b0;
        i_rst_n <= 1'b0;
        clear_scanner();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_delimiter();
        test_unit_split();
        test_ignored_start_codes();
        test_random_streams(RANDOM_BYTES);

        in_if.valid <= 1'b0;
        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
